FILE: design/rcbe_pkg.sv
package rcbe_pkg;

    // width of the message step counter
    localparam int CNT_W = 32;

    // handshake back from the shared remainder unit
    typedef struct packed {
        logic done;
        logic rem_zero;
    } mod_status_t;

endpackage

FILE: design/rcbe_ram.sv
module rcbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/rcbe_mod_unit.sv
module rcbe_mod_unit #(
    parameter int DIV_W = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rcbe_pkg::CNT_W-1:0]    dividend,
    input  logic [DIV_W-1:0]              divisor,
    output rcbe_pkg::mod_status_t         status
);

    localparam int BW = $clog2(rcbe_pkg::CNT_W);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [BW-1:0]              bit_reg, bit_next;
    logic [rcbe_pkg::CNT_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0]           div_reg, div_next;
    logic [DIV_W-1:0]           rem_reg, rem_next;

    logic [DIV_W:0]             trial;
    logic [DIV_W:0]             trial_sub;
    logic [DIV_W-1:0]           rem_step;

    // restoring remainder, one dividend bit per cycle
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[rcbe_pkg::CNT_W-1]};
        trial_sub = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg})
        begin
            rem_step = trial_sub[DIV_W-1:0];
        end
        else
        begin
            rem_step = trial[DIV_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        bit_next  = bit_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            bit_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            dvd_next = {dvd_reg[rcbe_pkg::CNT_W-2:0], 1'b0};
            bit_next = bit_reg + 1'b1;
            if (bit_reg == BW'(rcbe_pkg::CNT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule

FILE: design/rotor_cipher_byte_engine.sv
// rotor cipher byte engine: rotor substitution over an alphabet of N symbols
//
// input channel (in_valid / in_stall): one beat is one item. kind selects an
// encode or a load of the rotor wiring, reflector, plugboard or a rotor start
// position. loads give no result beat. an encode gives one result beat
// on the output channel (out_valid / out_stall). an encode runs plugboard,
// rotors 0..R-1, reflector, inverse rotors R-1..0, plugboard, one table
// read at a time, then stepping: each rotor j >= 1 needs counter mod (N*j)
// from the shared bit-serial remainder unit. a symbol at or above N skips
// the tables and the stepping and returns with its out-of-range flag set.
// in_stall is high for the whole of an encode; the next item is taken in the
// cycle after the result is registered. the output register lets an item be
// taken while the last result still waits, and a stalled receiver holds the
// block only when a newer result is ready to replace it.
// reset: alphabet size 256, rotor count 3, all positions 0, counter 1. the
// wiring, reflector and plugboard tables hold nothing defined until loaded.
// configuration goes through the apb port. the user must write it only while
// idle; the block itself does not enforce this.
module rotor_cipher_byte_engine #(
    parameter int MAX_ROTORS   = 8,
    parameter int MAX_ALPHABET = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  symbol,
    input  logic        message_start,
    input  logic [2:0]  rotor_index,
    input  logic [7:0]  table_index,
    input  logic [7:0]  table_value,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  cipher_symbol,
    output logic        symbol_out_of_range
);

    localparam int RW         = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1;
    localparam int AW         = (MAX_ALPHABET > 1) ? $clog2(MAX_ALPHABET) : 1;
    localparam int CW         = $clog2(MAX_ROTORS + 1);
    localparam int DW         = 9 + RW;
    localparam int WIRE_DEPTH = 1 << (RW + AW);

    // item kinds
    localparam logic [2:0] KIND_ENCODE    = 3'd0;
    localparam logic [2:0] KIND_WIRING    = 3'd1;
    localparam logic [2:0] KIND_REFLECTOR = 3'd2;
    localparam logic [2:0] KIND_PLUGBOARD = 3'd3;
    localparam logic [2:0] KIND_POSITION  = 3'd4;

    // register indexes, selected by paddr[2]
    localparam logic REG_ALPHABET_SIZE = 1'b0;
    localparam logic REG_ROTOR_COUNT   = 1'b1;

    // legal alphabet size range
    localparam logic [8:0] N_MIN = 9'd2;
    localparam logic [8:0] N_MAX = 9'd256;

    typedef enum logic [14:0] {
        ST_IDLE        = 15'b000000000000001,
        ST_PLUG_IN     = 15'b000000000000010,
        ST_PLUG_IN_LD  = 15'b000000000000100,
        ST_FWD_A       = 15'b000000000001000,
        ST_FWD_B       = 15'b000000000010000,
        ST_REFL        = 15'b000000000100000,
        ST_REFL_LD     = 15'b000000001000000,
        ST_INV_A       = 15'b000000010000000,
        ST_INV_B       = 15'b000000100000000,
        ST_PLUG_OUT    = 15'b000001000000000,
        ST_PLUG_OUT_LD = 15'b000010000000000,
        ST_STEP0       = 15'b000100000000000,
        ST_MOD_GO      = 15'b001000000000000,
        ST_MOD_WAIT    = 15'b010000000000000,
        ST_FINISH      = 15'b100000000000000
    } state_t;

    function automatic logic [7:0] step_pos(input logic [7:0] p, input logic [8:0] n);
        logic [8:0] s;
        s = {1'b0, p} + 9'd1;
        return (s >= n) ? 8'd0 : s[7:0];
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t                     state_reg, state_next;
    logic [RW-1:0]              j_reg, j_next;
    logic [7:0]                 code_reg, code_next;
    logic                       flag_reg, flag_next;
    logic [rcbe_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]                 pos_reg [MAX_ROTORS];
    logic [7:0]                 pos_next [MAX_ROTORS];
    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 out_sym_reg, out_sym_next;
    logic                       out_flag_reg, out_flag_next;
    logic [8:0]                 alphabet_size_reg;
    logic [3:0]                 rotor_count_reg;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_ALPHABET_SIZE: prdata = {23'd0, alphabet_size_reg};
            REG_ROTOR_COUNT:   prdata = {28'd0, rotor_count_reg};
            default:           prdata = '0;
        endcase
    end

    // effective alphabet size and rotor count
    logic [8:0]    n_eff;
    logic [CW-1:0] rc_eff;
    logic [RW-1:0] rc_top;

    always_comb
    begin
        if (alphabet_size_reg < N_MIN)
        begin
            n_eff = N_MIN;
        end
        else if (alphabet_size_reg > N_MAX)
        begin
            n_eff = N_MAX;
        end
        else
        begin
            n_eff = alphabet_size_reg;
        end

        if (rotor_count_reg == 4'd0)
        begin
            rc_eff = CW'(1);
        end
        else if (32'(rotor_count_reg) > MAX_ROTORS)
        begin
            rc_eff = CW'(MAX_ROTORS);
        end
        else
        begin
            rc_eff = CW'(rotor_count_reg);
        end
        rc_top = RW'(rc_eff - CW'(1));
    end

    // ------------------------------------------------------------------
    // index folding: table reads use the value modulo the table depth
    // ------------------------------------------------------------------
    logic [AW-1:0] fold_tab [256];

    for (genvar g = 0; g < 256; g++)
    begin : g_fold
        assign fold_tab[g] = AW'(g % MAX_ALPHABET);
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic in_acc;
    logic out_acc;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign cipher_symbol       = out_sym_reg;
    assign symbol_out_of_range = out_flag_reg;

    // ------------------------------------------------------------------
    // tables
    // ------------------------------------------------------------------
    logic          ri_ok, ti_ok, tv_ok;
    logic          fwd_we, inv_we, refl_we, plug_we;
    logic [RW-1:0] load_rotor;
    logic [7:0]    fwd_q, inv_q, refl_q, plug_q;
    logic [7:0]    pos_cur;
    logic [9:0]    sh_diff, sh_in;
    logic [9:0]    sh_sum, sh_out;
    logic [7:0]    wire_q;
    logic [RW+AW-1:0] wire_raddr;

    assign ri_ok      = 32'(rotor_index) < MAX_ROTORS;
    assign ti_ok      = 32'(table_index) < MAX_ALPHABET;
    assign tv_ok      = 32'(table_value) < MAX_ALPHABET;
    assign load_rotor = RW'(rotor_index);

    // a wiring beat fills the forward entry and its inverse together
    assign fwd_we  = in_acc && (kind == KIND_WIRING) && ri_ok && ti_ok;
    assign inv_we  = in_acc && (kind == KIND_WIRING) && ri_ok && tv_ok;
    assign refl_we = in_acc && (kind == KIND_REFLECTOR) && ti_ok;
    assign plug_we = in_acc && (kind == KIND_PLUGBOARD) && ti_ok;

    assign pos_cur = pos_reg[j_reg];

    // rotor entry shift: code - pos, wrapped by N once, low byte kept
    always_comb
    begin
        sh_diff = {2'b00, code_reg} - {2'b00, pos_cur};
        if (sh_diff[9])
        begin
            sh_in = sh_diff + {1'b0, n_eff};
        end
        else
        begin
            sh_in = sh_diff;
        end
    end

    assign wire_raddr = {j_reg, fold_tab[sh_in[7:0]]};
    assign wire_q     = (state_reg == ST_INV_B) ? inv_q : fwd_q;

    // rotor exit shift: table + pos, wrapped by N once
    always_comb
    begin
        sh_sum = {2'b00, wire_q} + {2'b00, pos_cur};
        if (sh_sum >= {1'b0, n_eff})
        begin
            sh_out = sh_sum - {1'b0, n_eff};
        end
        else
        begin
            sh_out = sh_sum;
        end
    end

    rcbe_ram #(
        .WIDTH (8),
        .DEPTH (WIRE_DEPTH)
    ) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr ({load_rotor, AW'(table_index)}),
        .wdata (table_value),
        .raddr (wire_raddr),
        .rdata (fwd_q)
    );

    rcbe_ram #(
        .WIDTH (8),
        .DEPTH (WIRE_DEPTH)
    ) u_inv_ram (
        .clk   (clk),
        .we    (inv_we),
        .waddr ({load_rotor, AW'(table_value)}),
        .wdata (table_index),
        .raddr (wire_raddr),
        .rdata (inv_q)
    );

    rcbe_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ALPHABET)
    ) u_refl_ram (
        .clk   (clk),
        .we    (refl_we),
        .waddr (AW'(table_index)),
        .wdata (table_value),
        .raddr (fold_tab[code_reg]),
        .rdata (refl_q)
    );

    rcbe_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ALPHABET)
    ) u_plug_ram (
        .clk   (clk),
        .we    (plug_we),
        .waddr (AW'(table_index)),
        .wdata (table_value),
        .raddr (fold_tab[code_reg]),
        .rdata (plug_q)
    );

    // ------------------------------------------------------------------
    // shared remainder unit: counter mod (N*j) for rotor stepping
    // ------------------------------------------------------------------
    logic                  mod_start;
    logic [DW-1:0]         mod_divisor;
    rcbe_pkg::mod_status_t mod_status;
    logic                  j_is_last;

    assign mod_divisor = DW'(n_eff) * DW'(j_reg);
    assign j_is_last   = (32'(j_reg) + 32'd1) == 32'(rc_eff);

    rcbe_mod_unit #(
        .DIV_W (DW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (cnt_reg),
        .divisor  (mod_divisor),
        .status   (mod_status)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        code_next      = code_reg;
        flag_next      = flag_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        out_sym_next   = out_sym_reg;
        out_flag_next  = out_flag_reg;
        out_valid_next = out_valid_reg;
        mod_start      = 1'b0;

        if (out_acc)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (kind == KIND_ENCODE)
                    begin
                        if (message_start)
                        begin
                            cnt_next = rcbe_pkg::CNT_W'(1);
                        end
                        // out-of-range symbols skip straight to the result
                        if ({1'b0, symbol} >= n_eff)
                        begin
                            flag_next  = 1'b1;
                            code_next  = 8'd0;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            flag_next  = 1'b0;
                            code_next  = symbol;
                            state_next = ST_PLUG_IN;
                        end
                    end
                    else if ((kind == KIND_POSITION) && ri_ok)
                    begin
                        pos_next[load_rotor] = table_value;
                    end
                end
            end
            ST_PLUG_IN:
            begin
                state_next = ST_PLUG_IN_LD;
            end
            ST_PLUG_IN_LD:
            begin
                code_next  = plug_q;
                j_next     = '0;
                state_next = ST_FWD_A;
            end
            ST_FWD_A:
            begin
                state_next = ST_FWD_B;
            end
            ST_FWD_B:
            begin
                code_next = sh_out[7:0];
                if (j_is_last)
                begin
                    state_next = ST_REFL;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_FWD_A;
                end
            end
            ST_REFL:
            begin
                state_next = ST_REFL_LD;
            end
            ST_REFL_LD:
            begin
                code_next  = refl_q;
                j_next     = rc_top;
                state_next = ST_INV_A;
            end
            ST_INV_A:
            begin
                state_next = ST_INV_B;
            end
            ST_INV_B:
            begin
                code_next = sh_out[7:0];
                if (j_reg == '0)
                begin
                    state_next = ST_PLUG_OUT;
                end
                else
                begin
                    j_next     = j_reg - 1'b1;
                    state_next = ST_INV_A;
                end
            end
            ST_PLUG_OUT:
            begin
                state_next = ST_PLUG_OUT_LD;
            end
            ST_PLUG_OUT_LD:
            begin
                code_next  = plug_q;
                state_next = ST_STEP0;
            end
            ST_STEP0:
            begin
                // rotor 0 steps on every in-range symbol
                pos_next[0] = step_pos(pos_reg[0], n_eff);
                j_next      = RW'(1);
                if (rc_eff > CW'(1))
                begin
                    state_next = ST_MOD_GO;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MOD_GO:
            begin
                mod_start  = 1'b1;
                state_next = ST_MOD_WAIT;
            end
            ST_MOD_WAIT:
            begin
                if (mod_status.done)
                begin
                    if (mod_status.rem_zero)
                    begin
                        pos_next[j_reg] = step_pos(pos_cur, n_eff);
                    end
                    if (j_is_last)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_MOD_GO;
                    end
                end
            end
            ST_FINISH:
            begin
                // wait only while an older result is still held
                if (!out_valid_reg || !out_stall)
                begin
                    out_sym_next   = code_reg;
                    out_flag_next  = flag_reg;
                    out_valid_next = 1'b1;
                    if (!flag_reg)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cnt_reg           <= rcbe_pkg::CNT_W'(1);
            out_valid_reg     <= 1'b0;
            alphabet_size_reg <= N_MAX;
            rotor_count_reg   <= 4'd3;
            for (int i = 0; i < MAX_ROTORS; i++)
            begin
                pos_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            if (cfg_write)
            begin
                unique case (paddr[2])
                    REG_ALPHABET_SIZE: alphabet_size_reg <= pwdata[8:0];
                    REG_ROTOR_COUNT:   rotor_count_reg   <= pwdata[3:0];
                    default:           alphabet_size_reg <= alphabet_size_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg        <= j_next;
        code_reg     <= code_next;
        flag_reg     <= flag_next;
        out_sym_reg  <= out_sym_next;
        out_flag_reg <= out_flag_next;
    end

endmodule

FILE: tb/rotor_cipher_byte_engine_tb.sv
`timescale 1ns / 1ps

module rotor_cipher_byte_engine_tb;

    import rcbe_pkg::*;

    // item kinds on the input channel
    typedef enum logic [2:0] {
        KIND_ENCODE,
        KIND_WIRING,
        KIND_REFLECTOR,
        KIND_PLUGBOARD,
        KIND_POSITION,
        KIND_SPARE5,
        KIND_SPARE6,
        KIND_SPARE7
    } item_kind_e;

    // apb register addresses
    localparam logic [2:0] ADDR_ALPHABET = 3'd0;
    localparam logic [2:0] ADDR_ROTORS   = 3'd4;

    localparam int SETTLE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 550;

    typedef struct {
        item_kind_e  kind;
        logic [7:0]  symbol;
        logic        msg_start;
        logic [2:0]  rotor_sel;
        logic [7:0]  tab_idx;
        logic [7:0]  tab_val;
    } beat_t;

    typedef struct {
        logic [7:0] cipher;
        logic       flagged;
    } cipher_res_t;

    // dut signals, the inputs all known from time zero
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  kind = '0;
    logic [7:0]  symbol = '0;
    logic        message_start = 1'b0;
    logic [2:0]  rotor_index = '0;
    logic [7:0]  table_index = '0;
    logic [7:0]  table_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  cipher_symbol;
    logic        symbol_out_of_range;

    // predictor state: tables, rotor positions, step counter, settings
    logic [7:0]       fwd_wiring [0:2047];
    logic [7:0]       inv_wiring [0:2047];
    logic [7:0]       refl_tab [0:255];
    logic [7:0]       plug_tab [0:255];
    logic [7:0]       rotor_pos [0:7] = '{default: 8'd0};
    logic [CNT_W-1:0] msg_steps = 1;
    logic [8:0]       cfg_alpha = 9'd256;
    logic [3:0]       cfg_rotors = 4'd3;

    cipher_res_t expected_cipher_q[$];

    int errors = 0;
    int beats_sent = 0;
    int fill_beats = 0;
    int results_checked = 0;
    int settings_used = 0;
    int random_items = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    // receiver stall pattern state
    int stall_mode = 0;
    int stall_mode_left = 0;
    int stall_hold = 0;

    item_kind_e spare_kinds[3] = '{KIND_SPARE5, KIND_SPARE6, KIND_SPARE7};

    rotor_cipher_byte_engine u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .kind                (kind),
        .symbol              (symbol),
        .message_start       (message_start),
        .rotor_index         (rotor_index),
        .table_index         (table_index),
        .table_value         (table_value),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .cipher_symbol       (cipher_symbol),
        .symbol_out_of_range (symbol_out_of_range)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // alphabet size clamps to 2..256
    function automatic int alpha_in_use();
        if (cfg_alpha < 2) return 2;
        if (cfg_alpha > 256) return 256;
        return int'(cfg_alpha);
    endfunction

    // rotor count clamps to 1..8
    function automatic int rotors_in_use();
        if (cfg_rotors < 1) return 1;
        if (cfg_rotors > 8) return 8;
        return int'(cfg_rotors);
    endfunction

    // one pass through rotor r: shift in by position, look up, shift back out;
    // the arithmetic is plain integer and only the low byte survives
    function automatic logic [7:0] rotor_lookup(input bit use_inverse, input logic [2:0] r,
                                                input logic [7:0] v, input int n);
        int         s;
        logic [7:0] idx;
        logic [7:0] hit;
        s = int'(v) - int'(rotor_pos[r]);
        if (s < 0)
            s += n;
        idx = 8'(s);
        hit = use_inverse ? inv_wiring[{r, idx}] : fwd_wiring[{r, idx}];
        s = int'(hit) + int'(rotor_pos[r]);
        if (s >= n)
            s -= n;
        return 8'(s);
    endfunction

    // a position at or above n-1 wraps to zero
    function automatic void advance_rotor(input int r, input int n);
        int p;
        p = int'(rotor_pos[r]) + 1;
        if (p >= n)
            p = 0;
        rotor_pos[r] = 8'(p);
    endfunction

    function automatic cipher_res_t encipher(input logic [7:0] sym, input logic start);
        cipher_res_t res;
        int          n;
        int          rc;
        logic [7:0]  code;
        n  = alpha_in_use();
        rc = rotors_in_use();
        if (start)
            msg_steps = 1;
        // out-of-range symbol: flagged, nothing steps, counter holds
        if (int'(sym) >= n)
        begin
            res.cipher  = 8'd0;
            res.flagged = 1'b1;
            return res;
        end
        code = plug_tab[sym];
        for (int j = 0; j < rc; j++)
            code = rotor_lookup(1'b0, 3'(j), code, n);
        code = refl_tab[code];
        for (int j = rc - 1; j >= 0; j--)
            code = rotor_lookup(1'b1, 3'(j), code, n);
        code = plug_tab[code];
        // rotor 0 always steps, rotor j when counter mod n*j is zero
        advance_rotor(0, n);
        for (int j = 1; j < rc; j++)
            if ((msg_steps % CNT_W'(n * j)) == 0)
                advance_rotor(j, n);
        msg_steps += 1;
        res.cipher  = code;
        res.flagged = 1'b0;
        return res;
    endfunction

    // apply one accepted beat to the predictor
    function automatic void absorb_beat(input beat_t b);
        case (b.kind)
            KIND_ENCODE:
                expected_cipher_q.push_back(encipher(b.symbol, b.msg_start));
            KIND_WIRING:
            begin
                fwd_wiring[{b.rotor_sel, b.tab_idx}] = b.tab_val;
                inv_wiring[{b.rotor_sel, b.tab_val}] = b.tab_idx;
            end
            KIND_REFLECTOR:
                refl_tab[b.tab_idx] = b.tab_val;
            KIND_PLUGBOARD:
                plug_tab[b.tab_idx] = b.tab_val;
            KIND_POSITION:
                rotor_pos[b.rotor_sel] = b.tab_val;
            default:
                ; // spare kinds are dropped by the block
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // fields the kind does not use still get random values
    function automatic beat_t fresh_beat(input item_kind_e k);
        beat_t b;
        b.kind      = k;
        b.symbol    = 8'($urandom);
        b.msg_start = 1'($urandom);
        b.rotor_sel = 3'($urandom);
        b.tab_idx   = 8'($urandom);
        b.tab_val   = 8'($urandom);
        return b;
    endfunction

    // drive one beat, wait for it to be taken, then maybe open a gap
    task automatic send_item(input beat_t b);
        int gap;
        in_valid      <= 1'b1;
        kind          <= b.kind;
        symbol        <= b.symbol;
        message_start <= b.msg_start;
        rotor_index   <= b.rotor_sel;
        table_index   <= b.tab_idx;
        table_value   <= b.tab_val;
        do
            @(posedge clk);
        while (in_stall);
        absorb_beat(b);
        beats_sent++;
        // bursts of random length, gaps between them, some bursts back to back
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic encode(input logic [7:0] sym, input logic start);
        beat_t b;
        b = fresh_beat(KIND_ENCODE);
        b.symbol    = sym;
        b.msg_start = start;
        send_item(b);
    endtask

    task automatic load(input item_kind_e k, input logic [2:0] r, input logic [7:0] idx,
                        input logic [7:0] val);
        beat_t b;
        b = fresh_beat(k);
        b.rotor_sel = r;
        b.tab_idx   = idx;
        b.tab_val   = val;
        send_item(b);
    endtask

    // drop valid, let every result come back, then give loads time to finish
    task automatic settle_block();
        in_valid <= 1'b0;
        while (expected_cipher_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int alpha, input int rotors);
        settle_block();
        write_reg(ADDR_ALPHABET, 32'(alpha));
        cfg_alpha = 9'(alpha);
        write_reg(ADDR_ROTORS, 32'(rotors));
        cfg_rotors = 4'(rotors);
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every rotor gets a full permutation so the inverse tables are complete,
    // reflector and plugboard get all 256 entries; nothing unloaded is read later
    task automatic test_table_load();
        int perm [256];
        int pick;
        int tmp;
        for (int t = 0; t < 10; t++)
        begin
            for (int i = 0; i < 256; i++)
                perm[i] = i;
            for (int i = 255; i > 0; i--)
            begin
                pick       = $urandom_range(0, i);
                tmp        = perm[i];
                perm[i]    = perm[pick];
                perm[pick] = tmp;
            end
            for (int i = 0; i < 256; i++)
            begin
                if (t < 8)
                    load(KIND_WIRING, 3'(t), 8'(i), 8'(perm[i]));
                else if (t == 8)
                    load(KIND_REFLECTOR, 3'($urandom), 8'(i), 8'(perm[i]));
                else
                    load(KIND_PLUGBOARD, 3'($urandom), 8'(i), 8'(perm[i]));
                fill_beats++;
            end
        end
    endtask

    task automatic test_directed_cases();
        // reset settings: 256 symbols, 3 rotors
        encode(8'h00, 1'b1);
        encode(8'hFF, 1'b0);
        for (int i = 0; i < 3; i++)
            send_item(fresh_beat(spare_kinds[i]));
        // position at n-1 wraps to zero on the step
        load(KIND_POSITION, 3'd0, 8'd0, 8'hFF);
        encode(8'h80, 1'b0);
        load(KIND_POSITION, 3'd7, 8'd0, 8'h5A);
        encode(8'h55, 1'b1);

        // small alphabet, one rotor
        set_config(26, 1);
        encode(8'd25, 1'b1);
        encode(8'd26, 1'b0);
        // flagged symbol still restarts the counter
        encode(8'hFF, 1'b1);
        load(KIND_POSITION, 3'd0, 8'd0, 8'd25);
        encode(8'd3, 1'b0);
        // position above the alphabet
        load(KIND_POSITION, 3'd0, 8'd0, 8'd200);
        encode(8'd7, 1'b0);
        // wiring value above the alphabet
        load(KIND_WIRING, 3'd0, 8'd5, 8'd200);
        encode(8'd0, 1'b0);

        // register values below the legal range
        set_config(0, 0);
        encode(8'd1, 1'b1);
        encode(8'd2, 1'b0);

        // register values above the legal range
        set_config(511, 15);
        encode(8'hFF, 1'b1);
        encode(8'h00, 1'b0);
    endtask

    // long messages so the higher rotors step
    task automatic test_rotor_carry();
        set_config(256, 2);
        for (int k = 0; k < 260; k++)
            encode(8'($urandom), k == 0);
        set_config(3, 8);
        for (int k = 0; k < 50; k++)
            encode(8'($urandom_range(0, 2)), k == 0);
    endtask

    // one item, or a pair of wiring loads, that breaks the usual message flow
    task automatic inject_noise();
        int         n;
        logic [2:0] r;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] va;
        logic [7:0] vb;
        n = alpha_in_use();
        case ($urandom_range(0, 5))
            0:
                encode((n < 256) ? 8'($urandom_range(n, 255)) : 8'($urandom), 1'($urandom));
            1:
            begin
                send_item(fresh_beat(spare_kinds[$urandom_range(0, 2)]));
                return;
            end
            2:
            begin
                // swap two wiring entries, keeps the rotor a permutation
                r  = 3'($urandom_range(0, rotors_in_use() - 1));
                a  = 8'($urandom_range(0, n - 1));
                b  = 8'($urandom_range(0, n - 1));
                va = fwd_wiring[{r, a}];
                vb = fwd_wiring[{r, b}];
                load(KIND_WIRING, r, a, vb);
                load(KIND_WIRING, r, b, va);
                random_items++;
            end
            3:
                load(($urandom_range(0, 1) == 0) ? KIND_REFLECTOR : KIND_PLUGBOARD,
                     3'($urandom), 8'($urandom), 8'($urandom));
            4:
                load(KIND_WIRING, 3'($urandom), 8'($urandom), 8'($urandom));
            default:
                load(KIND_POSITION, 3'($urandom), 8'($urandom), 8'($urandom));
        endcase
        random_items++;
    endtask

    task automatic random_message(input int msg_len);
        int n;
        n = alpha_in_use();
        for (int r = 0; r < rotors_in_use(); r++)
            if ($urandom_range(0, 2) == 0)
            begin
                load(KIND_POSITION, 3'(r), 8'($urandom),
                     ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, n - 1)));
                random_items++;
            end
        for (int k = 0; k < msg_len; k++)
        begin
            if ($urandom_range(0, 11) == 0)
                inject_noise();
            encode(($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, n - 1)),
                   k == 0);
            random_items++;
        end
    endtask

    task automatic test_random_traffic();
        int alpha_pick [4] = '{2, 256, 1, 400};
        int rotor_pick [4] = '{8, 1, 0, 12};
        int alpha;
        int rotors;
        int phase_end;
        for (int p = 0; random_items < RANDOM_ITEMS; p++)
        begin
            if (p < 4)
            begin
                alpha  = alpha_pick[p];
                rotors = rotor_pick[p];
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0, 1, 2: alpha = $urandom_range(2, 40);
                    3:       alpha = $urandom_range(41, 256);
                    default: alpha = $urandom_range(0, 511);
                endcase
                rotors = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(1, 8);
            end
            set_config(alpha, rotors);
            phase_end = random_items + $urandom_range(30, 80);
            while (random_items < phase_end)
                random_message($urandom_range(1, 25));
        end
    endtask

    // ------------------------------------------------------------------
    // result checking and receiver stalls
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_cipher_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, got cipher %0h flag %0b",
                         $time, cipher_symbol, symbol_out_of_range);
                errors++;
            end
            else
            begin
                if (cipher_symbol !== expected_cipher_q[0].cipher)
                begin
                    $display("%0t: cipher_symbol expected %0h actual %0h",
                             $time, expected_cipher_q[0].cipher, cipher_symbol);
                    errors++;
                end
                if (symbol_out_of_range !== expected_cipher_q[0].flagged)
                begin
                    $display("%0t: symbol_out_of_range expected %0b actual %0b",
                             $time, expected_cipher_q[0].flagged, symbol_out_of_range);
                    errors++;
                end
                void'(expected_cipher_q.pop_front());
                results_checked++;
            end
        end

        // stall modes: free running, scattered stalls, long stall bursts
        if (stall_mode_left == 0)
        begin
            stall_mode      = $urandom_range(0, 2);
            stall_mode_left = $urandom_range(20, 200);
        end
        else
            stall_mode_left--;
        case (stall_mode)
            0:
                out_stall <= 1'b0;
            1:
                out_stall <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (stall_hold > 0)
                begin
                    stall_hold--;
                    out_stall <= 1'b1;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    stall_hold = $urandom_range(1, 40);
                    out_stall <= 1'b1;
                end
                else
                    out_stall <= 1'b0;
            end
        endcase
    end

    // hang detector: cycles without any handshake on either channel or apb
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_cipher_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_load();
        test_directed_cases();
        test_rotor_carry();
        test_random_traffic();

        settle_block();

        $display("run covered %0d beats (%0d table fill, %0d random), %0d results checked",
                 beats_sent, fill_beats, random_items, results_checked);
        $display("over %0d register settings, %0d mismatches", settings_used, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
